// ----- src/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VCR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/vcr_pkg.sv -----
// Types, codes and helper functions of the viewpoint circle block.
`default_nettype none
package vcr_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_SPACE  = 3'd2,
        CMD_CENTER = 3'd3,
        CMD_CIRCLE = 3'd4
    } t_cmd;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_FOV    = 2'd1;
    localparam logic [1:0] REG_TOL    = 2'd2;

    localparam logic [19:0] RADIUS_RST = 20'd19661;
    localparam logic [19:0] FOV_RST    = 20'd13107;
    localparam logic [19:0] TOL_RST    = 20'd3277;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_C_PREP,
        ST_C_RUN,
        ST_P_MUL,
        ST_P_ADD,
        ST_P_WS,
        ST_P_BOX,
        ST_P_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] box_low_x;
        logic signed [31:0] box_low_y;
        logic signed [31:0] box_low_z;
        logic signed [31:0] box_high_x;
        logic signed [31:0] box_high_y;
        logic signed [31:0] box_high_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               reachable;
        logic [5:0]         item_index;
        logic               last_item;
    } t_out;

    typedef struct packed {
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] lz;
        logic signed [31:0] hx;
        logic signed [31:0] hy;
        logic signed [31:0] hz;
    } t_box;

    localparam int BOX_W = $bits(t_box);

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [16:0] quarter_sine(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd0;
            5'd1:    r = 17'd6424;
            5'd2:    r = 17'd12785;
            5'd3:    r = 17'd19024;
            5'd4:    r = 17'd25080;
            5'd5:    r = 17'd30893;
            5'd6:    r = 17'd36410;
            5'd7:    r = 17'd41576;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd50660;
            5'd10:   r = 17'd54491;
            5'd11:   r = 17'd57798;
            5'd12:   r = 17'd60547;
            5'd13:   r = 17'd62714;
            5'd14:   r = 17'd64277;
            5'd15:   r = 17'd65220;
            5'd16:   r = 17'd65536;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // sine of phase/64 turns, Q1.16
    function automatic logic signed [17:0] sine64(input logic [5:0] phase);
        logic [16:0] m;
        if (phase[4]) begin
            m = quarter_sine(5'd16 - {1'b0, phase[3:0]});
        end else begin
            m = quarter_sine({1'b0, phase[3:0]});
        end
        return phase[5] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage
`default_nettype wire

// ----- src/vcr_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module vcr_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0]   i_waddr,
    input  wire logic [W-1:0]                         i_wdata,
    input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0]   i_raddr,
    output logic      [W-1:0]                         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/viewpoint_circle_reachability.sv -----
// Viewpoint circle reachability: obstacle table, workspace, centers and circle points.
// Input channel: one beat carries a command and box / center coordinates.
//   Clear, add box and set workspace give no result.
//   Centers of a target: a setup step in ST_C_PREP, then one center a cycle
//   while the output is free, up to MAX_CENTERS, the last flagged with last_item.
//   Circle: POINTS results; each point passes the multiply, add and workspace
//   states, a scan of the stored boxes, and the output state (the scan stops at
//   the first hit and is skipped when the point is outside the workspace). The
//   obstacle table memory gives one box per cycle during the scan.
// Output channel: one output register; the result waits there while the
// receiver stalls and the block holds its work until the register is free.
// The input is stalled while a centers or circle command is in progress.
// Configuration: write enable, index and 20-bit data; writes are meant for
// an idle block.
// Reset (synchronous, active low): empty table, workspace covering the whole
// coordinate range, register reset values, no pending result.
`default_nettype none
`include "assert_macros.svh"
module viewpoint_circle_reachability #(
    parameter int MAX_BOXES   = 16,
    parameter int POINTS      = 64,
    parameter int MAX_CENTERS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [19:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire vcr_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output vcr_pkg::t_out      o_out_data
);
    localparam int AW   = MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1;
    localparam int CW   = $clog2(MAX_BOXES + 1);
    localparam int Q64  = 64 / POINTS;
    localparam int R64  = 64 % POINTS;
    localparam int HALF = POINTS / 2;
    localparam logic [CW-1:0] MAXB = CW'(MAX_BOXES);
    localparam logic [5:0] LAST_PT  = 6'(POINTS - 1);
    localparam logic [5:0] LAST_CEN = 6'(MAX_CENTERS - 1);
    // floor(x/5) = (x * M5) >> 26 for x below 2^23
    localparam logic [23:0] M5 = 24'd13421773;

    vcr_pkg::t_state r_state, n_state;

    logic [19:0] r_radius, r_fov_reg, r_tol;
    logic [CW-1:0] r_count;
    logic signed [31:0] r_wlx, r_wly, r_wlz, r_whx, r_why, r_whz;

    logic signed [31:0] r_mx, r_my, r_lz;
    logic signed [33:0] r_height, r_rem;
    logic [25:0] r_acc;
    logic [5:0] r_i;
    logic r_single;
    logic [20:0] r_q5;

    logic signed [31:0] r_cx, r_cy, r_cz, r_px, r_py;
    logic signed [38:0] r_prod_x, r_prod_y;
    logic [5:0] r_j, r_ph;
    logic [6:0] r_rr;
    logic [CW-1:0] r_b;
    logic r_ok;

    logic r_out_valid;
    vcr_pkg::t_out r_out;

    logic accept, slot, c_last, ws_ok, hit, ram_we, emit;
    logic [AW-1:0] ram_raddr;
    vcr_pkg::t_box ram_rd, ram_wd;
    logic [19:0] fov;
    logic [CW-1:0] b_next;

    assign fov    = (r_fov_reg == 20'd0) ? 20'd1 : r_fov_reg;
    assign accept = i_in_valid && !o_in_stall;
    assign slot   = !r_out_valid || !i_out_stall;
    assign b_next = r_b + CW'(1);

    assign c_last = r_single || (r_i == LAST_CEN) ||
                    !((r_rem >= $signed({14'd0, fov})) || (r_rem > $signed({14'd0, r_tol})));

    assign ws_ok = (r_px >= r_wlx) && (r_px <= r_whx) && (r_py >= r_wly) &&
                   (r_py <= r_why) && (r_cz >= r_wlz) && (r_cz <= r_whz);
    assign hit   = (r_px >= ram_rd.lx) && (r_px <= ram_rd.hx) && (r_py >= ram_rd.ly) &&
                   (r_py <= ram_rd.hy) && (r_cz >= ram_rd.lz) && (r_cz <= ram_rd.hz);

    assign ram_wd = '{lx: i_in_data.box_low_x, ly: i_in_data.box_low_y,
                      lz: i_in_data.box_low_z, hx: i_in_data.box_high_x,
                      hy: i_in_data.box_high_y, hz: i_in_data.box_high_z};

    vcr_ram #(.W(vcr_pkg::BOX_W), .D(MAX_BOXES)) u_boxes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wd),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            vcr_pkg::ST_IDLE: begin
                if (accept && i_in_data.command == vcr_pkg::CMD_CENTER) begin
                    n_state = vcr_pkg::ST_C_PREP;
                end else if (accept && i_in_data.command == vcr_pkg::CMD_CIRCLE) begin
                    n_state = vcr_pkg::ST_P_MUL;
                end
            end
            vcr_pkg::ST_C_PREP: n_state = vcr_pkg::ST_C_RUN;
            vcr_pkg::ST_C_RUN: begin
                if (slot && c_last) n_state = vcr_pkg::ST_IDLE;
            end
            vcr_pkg::ST_P_MUL: n_state = vcr_pkg::ST_P_ADD;
            vcr_pkg::ST_P_ADD: n_state = vcr_pkg::ST_P_WS;
            vcr_pkg::ST_P_WS: begin
                n_state = (ws_ok && r_count != '0) ? vcr_pkg::ST_P_BOX : vcr_pkg::ST_P_OUT;
            end
            vcr_pkg::ST_P_BOX: begin
                if (hit || b_next >= r_count) n_state = vcr_pkg::ST_P_OUT;
            end
            vcr_pkg::ST_P_OUT: begin
                if (slot) begin
                    n_state = (r_j == LAST_PT) ? vcr_pkg::ST_IDLE : vcr_pkg::ST_P_MUL;
                end
            end
            default: n_state = vcr_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = (r_state != vcr_pkg::ST_IDLE);
        ram_we     = accept && i_in_data.command == vcr_pkg::CMD_ADD && r_count < MAXB;
        emit       = slot && (r_state == vcr_pkg::ST_C_RUN || r_state == vcr_pkg::ST_P_OUT);
        case (r_state)
            vcr_pkg::ST_P_BOX: ram_raddr = b_next[AW-1:0];
            default:           ram_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic signed [33:0] z;
        logic signed [22:0] dx, dy;
        logic [6:0] rs;
        if (!i_rst_n) begin
            r_state     <= vcr_pkg::ST_IDLE;
            r_radius    <= vcr_pkg::RADIUS_RST;
            r_fov_reg   <= vcr_pkg::FOV_RST;
            r_tol       <= vcr_pkg::TOL_RST;
            r_count     <= '0;
            r_wlx       <= 32'sh8000_0000;
            r_wly       <= 32'sh8000_0000;
            r_wlz       <= 32'sh8000_0000;
            r_whx       <= 32'sh7FFF_FFFF;
            r_why       <= 32'sh7FFF_FFFF;
            r_whz       <= 32'sh7FFF_FFFF;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= emit || (r_out_valid && i_out_stall);

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vcr_pkg::REG_RADIUS: r_radius  <= i_cfg_data;
                    vcr_pkg::REG_FOV:    r_fov_reg <= i_cfg_data;
                    vcr_pkg::REG_TOL:    r_tol     <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                vcr_pkg::ST_IDLE: begin
                    if (accept) begin
                        case (i_in_data.command)
                            vcr_pkg::CMD_CLEAR: r_count <= '0;
                            vcr_pkg::CMD_ADD: begin
                                if (r_count < MAXB) r_count <= r_count + CW'(1);
                            end
                            vcr_pkg::CMD_SPACE: begin
                                r_wlx <= i_in_data.box_low_x;
                                r_wly <= i_in_data.box_low_y;
                                r_wlz <= i_in_data.box_low_z;
                                r_whx <= i_in_data.box_high_x;
                                r_why <= i_in_data.box_high_y;
                                r_whz <= i_in_data.box_high_z;
                            end
                            vcr_pkg::CMD_CENTER: begin
                                r_mx <= 32'(34'(i_in_data.box_low_x) +
                                        ((34'(i_in_data.box_high_x) -
                                          34'(i_in_data.box_low_x)) >>> 1));
                                r_my <= 32'(34'(i_in_data.box_low_y) +
                                        ((34'(i_in_data.box_high_y) -
                                          34'(i_in_data.box_low_y)) >>> 1));
                                r_lz     <= i_in_data.box_low_z;
                                r_height <= 34'(i_in_data.box_high_z) -
                                            34'(i_in_data.box_low_z);
                                r_acc    <= '0;
                                r_i      <= '0;
                            end
                            vcr_pkg::CMD_CIRCLE: begin
                                r_cx <= i_in_data.center_x;
                                r_cy <= i_in_data.center_y;
                                r_cz <= i_in_data.center_z;
                                r_j  <= '0;
                                r_ph <= '0;
                                r_rr <= 7'(HALF);
                            end
                            default: ;
                        endcase
                    end
                end
                vcr_pkg::ST_C_PREP: begin
                    r_single <= r_height <= ($signed({14'd0, fov}) + $signed({14'd0, r_tol}));
                    r_rem    <= r_height - $signed({14'd0, fov});
                    // (6*fov + 2) / 5
                    r_q5     <= 21'(((47'({fov, 2'd0}) + 47'({fov, 1'b0}) + 47'd2) *
                                     47'(M5)) >> 26);
                end
                vcr_pkg::ST_C_RUN: begin
                    if (slot) begin
                        if (r_single) begin
                            z = 34'(r_lz) - $signed({13'd0, r_q5});
                        end else if (c_last) begin
                            z = 34'(r_lz) + $signed({8'd0, r_acc}) +
                                $signed({11'd0, 23'(({3'd0, fov} * 23'd5 + 23'd2) >> 2)});
                        end else begin
                            z = 34'(r_lz) + $signed({8'd0, r_acc}) +
                                $signed({13'd0, 21'(({1'b0, fov} + 21'd1) >> 1)});
                        end
                        r_out.point_x    <= r_mx;
                        r_out.point_y    <= r_my;
                        r_out.point_z    <= vcr_pkg::sat32(z);
                        r_out.reachable  <= 1'b0;
                        r_out.item_index <= r_i;
                        r_out.last_item  <= c_last;
                        r_rem <= r_rem - $signed({14'd0, fov});
                        r_acc <= r_acc + {6'd0, fov};
                        r_i   <= r_i + 6'd1;
                    end
                end
                vcr_pkg::ST_P_MUL: begin
                    r_prod_x <= $signed({1'b0, r_radius}) * vcr_pkg::sine64(r_ph + 6'd16);
                    r_prod_y <= $signed({1'b0, r_radius}) * vcr_pkg::sine64(r_ph);
                end
                vcr_pkg::ST_P_ADD: begin
                    dx = 23'((r_prod_x + 39'sd32768) >>> 16);
                    dy = 23'((r_prod_y + 39'sd32768) >>> 16);
                    r_px <= vcr_pkg::sat32(34'(r_cx) + 34'(dx));
                    r_py <= vcr_pkg::sat32(34'(r_cy) + 34'(dy));
                end
                vcr_pkg::ST_P_WS: begin
                    r_ok <= ws_ok;
                    r_b  <= '0;
                end
                vcr_pkg::ST_P_BOX: begin
                    if (hit) r_ok <= 1'b0;
                    r_b <= b_next;
                end
                vcr_pkg::ST_P_OUT: begin
                    if (slot) begin
                        r_out.point_x    <= r_px;
                        r_out.point_y    <= r_py;
                        r_out.point_z    <= r_cz;
                        r_out.reachable  <= r_ok;
                        r_out.item_index <= r_j;
                        r_out.last_item  <= (r_j == LAST_PT);
                        r_j <= r_j + 6'd1;
                        // phase = round(j*64/POINTS), kept as quotient and remainder
                        rs = r_rr + 7'(R64);
                        if (rs >= 7'(POINTS)) begin
                            r_rr <= rs - 7'(POINTS);
                            r_ph <= r_ph + 6'(Q64 + 1);
                        end else begin
                            r_rr <= rs;
                            r_ph <= r_ph + 6'(Q64);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `VCR_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= MAXB)
    `VCR_ASSERT_IMPL(a_scan_range, i_clk, i_rst_n, r_state == vcr_pkg::ST_P_BOX, r_b < r_count)
    `VCR_ASSERT_NEXT(a_no_overwrite, i_clk, i_rst_n, r_out_valid && i_out_stall,
                     r_out_valid && $stable(r_out))

endmodule
`default_nettype wire
